// File: rtl/core/assert_macros.svh
// Assertion macros for the checker of the sphere pixel neighbour block.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define SPR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define SPR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/spr_pkg.sv
// Package for the sphere pixel neighbour block: widths, grid tables and codes.
// Used by every module of the block but the queue; depends on nothing.
package spr_pkg;

  localparam int IDX_W = 30;
  localparam int ORD_W = 4;
  localparam int DIR_W = 3;
  localparam int FACE_W = 4;
  localparam int NFACE = 12;
  localparam int NSLOT = 9;
  localparam int NDIR = 8;
  localparam int WIDE_W = 32;
  localparam int MAX_ORDER_DEF = 13;

  localparam logic [FACE_W-1:0] FACE_NONE = 4'd15;
  localparam logic [DIR_W-1:0] DIR_LAST = 3'd7;

  localparam logic [2:0] RING_ROW [NFACE] = '{3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
                                              3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4};
  localparam logic [2:0] RING_COL [NFACE] = '{3'd1, 3'd3, 3'd5, 3'd7, 3'd0, 3'd2,
                                              3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd7};
  localparam logic signed [1:0] STEP_X [NDIR] = '{-2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                                  2'sd1, 2'sd1, 2'sd0, -2'sd1};
  localparam logic signed [1:0] STEP_Y [NDIR] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                                  2'sd0, -2'sd1, -2'sd1, -2'sd1};

  localparam logic [FACE_W-1:0] ADJ_FACE [NSLOT][NFACE] = '{
    '{4'd8, 4'd9, 4'd10, 4'd11, 4'd15, 4'd15, 4'd15, 4'd15, 4'd10, 4'd11, 4'd8, 4'd9},
    '{4'd5, 4'd6, 4'd7, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11, 4'd9, 4'd10, 4'd11, 4'd8},
    '{4'd15, 4'd15, 4'd15, 4'd15, 4'd5, 4'd6, 4'd7, 4'd4, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd8, 4'd9, 4'd10, 4'd11, 4'd8, 4'd9, 4'd10},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd1, 4'd2, 4'd3, 4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4},
    '{4'd15, 4'd15, 4'd15, 4'd15, 4'd7, 4'd4, 4'd5, 4'd6, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd3, 4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7},
    '{4'd2, 4'd3, 4'd0, 4'd1, 4'd15, 4'd15, 4'd15, 4'd15, 4'd0, 4'd1, 4'd2, 4'd3}};

  localparam logic [2:0] ADJ_SWAP [NSLOT][NFACE] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd3, 3'd3, 3'd3, 3'd3},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd6, 3'd6, 3'd6, 3'd6},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd5, 3'd5, 3'd5, 3'd5},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd5, 3'd5, 3'd5, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd6, 3'd6, 3'd6, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd3, 3'd3, 3'd3, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}};

  localparam logic [1:0] REG_NORTH = 2'd0;
  localparam logic [1:0] REG_EQ = 2'd1;
  localparam logic [1:0] REG_SOUTH = 2'd2;

endpackage

// File: rtl/core/spr_front.sv
// Front end of the sphere pixel neighbour block: accepts a pixel index and decodes it
// into face and in-face coordinates. Depends on spr_pkg.
module spr_front #(
  parameter int MAX_ORDER = spr_pkg::MAX_ORDER_DEF,
  parameter int CW = MAX_ORDER + 1,
  parameter int DW = 1 + spr_pkg::FACE_W + 2 * CW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [spr_pkg::ORD_W-1:0] ord,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [spr_pkg::IDX_W-1:0] pixel_index,
  output logic                      push,
  output logic [DW-1:0]             push_data,
  input  logic                      full
);
  import spr_pkg::*;

  localparam int RW = MAX_ORDER + 3;
  localparam int SW = MAX_ORDER + 6;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQRT = 3'd1;
  localparam logic [2:0] ST_RING = 3'd2;
  localparam logic [2:0] ST_PHI = 3'd3;
  localparam logic [2:0] ST_FACE = 3'd4;
  localparam logic [2:0] ST_XY = 3'd5;

  logic [2:0] st;
  logic [1:0] sq_cnt;
  logic [IDX_W-1:0] p_r;
  logic [IDX_W-1:0] ip_r;
  logic [1:0] region;
  logic bad_r;
  logic [WIDE_W-1:0] sq_v;
  logic [WIDE_W-1:0] sq_r;
  logic [WIDE_W-1:0] sq_bit;
  logic [RW-1:0] iring;
  logic [RW-1:0] iphi;
  logic [RW-1:0] nr;
  logic ks;
  logic [FACE_W-1:0] face;

  logic [WIDE_W-1:0] n_w, npface, ncap, npix, p_w, ip_next, v_next;
  logic [1:0] region_next;
  logic bad_next;
  logic [WIDE_W-1:0] v_s, r_s, b_s;
  logic [WIDE_W-1:0] iring_ring, prod, iphi_n, iphi_s, iphi_e, ire, irm, ifm, ifp, q_w;
  logic [WIDE_W-1:0] iphi_m1, nr_w;
  logic [FACE_W-1:0] face_next;
  logic signed [SW-1:0] irt, ipt, px, py, n_s;
  logic accept;
  logic pushing;

  assign pushing = (st == ST_XY) && !full;
  assign in_ready = (st == ST_IDLE) || pushing;
  assign accept = in_valid && in_ready;
  assign push = pushing;

  always_comb begin
    n_w = WIDE_W'(1) << ord;
    npface = WIDE_W'(1) << {ord, 1'b0};
    ncap = (npface << 1) - (n_w << 1);
    npix = (npface << 3) + (npface << 2);
    p_w = WIDE_W'(pixel_index);
    bad_next = p_w >= npix;
    if (p_w < ncap) begin
      region_next = REG_NORTH;
      ip_next = p_w;
      v_next = (p_w << 1) + 1;
    end else if (p_w < npix - ncap) begin
      region_next = REG_EQ;
      ip_next = p_w - ncap;
      v_next = '0;
    end else begin
      region_next = REG_SOUTH;
      ip_next = npix - p_w;
      v_next = (ip_next << 1) - 1;
    end
  end

  always_comb begin
    v_s = sq_v;
    r_s = sq_r;
    b_s = sq_bit;
    for (int i = 0; i < 4; i++) begin
      if (v_s >= r_s + b_s) begin
        v_s = v_s - (r_s + b_s);
        r_s = (r_s >> 1) + b_s;
      end else begin
        r_s = r_s >> 1;
      end
      b_s = b_s >> 2;
    end
  end

  always_comb begin
    if (region == REG_EQ) begin
      iring_ring = (WIDE_W'(ip_r) >> (5'(ord) + 5'd2)) + n_w;
    end else begin
      iring_ring = (sq_r + 1) >> 1;
    end
    prod = WIDE_W'(iring) * (WIDE_W'(iring) - 1);
    iphi_n = WIDE_W'(p_r) + 1 - (prod << 1);
    iphi_s = (WIDE_W'(iring) << 2) + 1 - (WIDE_W'(ip_r) - (prod << 1));
    iphi_e = (WIDE_W'(ip_r) & ((n_w << 2) - 1)) + 1;
    iphi_m1 = WIDE_W'(iphi) - 1;
    nr_w = WIDE_W'(nr);
    if (iphi_m1 >= nr_w + (nr_w << 1)) q_w = 3;
    else if (iphi_m1 >= (nr_w << 1)) q_w = 2;
    else if (iphi_m1 >= nr_w) q_w = 1;
    else q_w = 0;
    ire = WIDE_W'(iring) - n_w + 1;
    irm = (n_w << 1) + 2 - ire;
    ifm = (WIDE_W'(iphi) - (ire >> 1) + n_w - 1) >> ord;
    ifp = (WIDE_W'(iphi) - (irm >> 1) + n_w - 1) >> ord;
    case (region)
      REG_NORTH: face_next = FACE_W'(q_w);
      REG_SOUTH: face_next = FACE_W'(q_w + 8);
      default: begin
        if (ifp == ifm) face_next = FACE_W'(ifp | 4);
        else if (ifp < ifm) face_next = FACE_W'(ifp);
        else if (ifm + 8 > 11) face_next = 4'd11;
        else face_next = FACE_W'(ifm + 8);
      end
    endcase
  end

  always_comb begin
    n_s = SW'(1) << ord;
    irt = $signed(SW'(iring)) - ($signed(SW'(RING_ROW[face])) << ord);
    ipt = ($signed(SW'(iphi)) <<< 1) - $signed(SW'(RING_COL[face])) * $signed(SW'(nr))
          - $signed(SW'(ks)) - SW'(1);
    if (ipt >= (n_s <<< 1)) ipt = ipt - (n_s <<< 3);
    px = (ipt - irt) >>> 1;
    py = (-ipt - irt) >>> 1;
    push_data = {bad_r, face, px[CW-1:0], py[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      sq_cnt <= '0;
    end else begin
      case (st)
        ST_SQRT: begin
          sq_cnt <= sq_cnt + 2'd1;
          if (sq_cnt == 2'd3) st <= ST_RING;
        end
        ST_RING: st <= ST_PHI;
        ST_PHI: st <= ST_FACE;
        ST_FACE: st <= ST_XY;
        ST_XY: if (pushing && !accept) st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase
      if (accept) begin
        sq_cnt <= '0;
        if (bad_next) st <= ST_XY;
        else if (region_next == REG_EQ) st <= ST_RING;
        else st <= ST_SQRT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r <= pixel_index;
      ip_r <= IDX_W'(ip_next);
      region <= region_next;
      bad_r <= bad_next;
      sq_v <= v_next;
      sq_r <= '0;
      sq_bit <= WIDE_W'(1) << 30;
      face <= '0;
      iring <= '0;
      iphi <= '0;
      nr <= '0;
      ks <= 1'b0;
    end else begin
      case (st)
        ST_SQRT: begin
          sq_v <= v_s;
          sq_r <= r_s;
          sq_bit <= b_s;
        end
        ST_RING: iring <= RW'(iring_ring);
        ST_PHI: begin
          case (region)
            REG_NORTH: begin
              iphi <= RW'(iphi_n);
              nr <= iring;
              ks <= 1'b0;
            end
            REG_SOUTH: begin
              iphi <= RW'(iphi_s);
              nr <= iring;
              ks <= 1'b0;
              iring <= RW'((n_w << 2) - WIDE_W'(iring));
            end
            default: begin
              iphi <= RW'(iphi_e);
              nr <= RW'(n_w);
              ks <= iring[0] ^ n_w[0];
            end
          endcase
        end
        ST_FACE: face <= face_next;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/spr_fifo.sv
// Short queue between the decoder and the neighbour pipeline of the sphere pixel block.
// Depends on nothing but its parameters.
module spr_fifo #(
  parameter int DW = 32,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] head,
  output logic          empty
);
  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;

  assign full = count == (AW + 1)'(DEPTH);
  assign empty = count == '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if ((push && !full) && !(pop && !empty)) count <= count + 1'b1;
      else if (!(push && !full) && (pop && !empty)) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/core/spr_back.sv
// Back end of the sphere pixel neighbour block: walks the eight directions of each
// decoded pixel, wraps across faces and re-encodes ring indexes. Depends on spr_pkg.
module spr_back #(
  parameter int MAX_ORDER = spr_pkg::MAX_ORDER_DEF,
  parameter int CW = MAX_ORDER + 1,
  parameter int DW = 1 + spr_pkg::FACE_W + 2 * CW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [spr_pkg::ORD_W-1:0] ord,
  input  logic [DW-1:0]             head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [spr_pkg::DIR_W-1:0] direction,
  output logic [spr_pkg::IDX_W-1:0] neighbour_index,
  output logic                      neighbour_present,
  output logic                      index_out_of_range,
  output logic                      last_of_run
);
  import spr_pkg::*;

  localparam int SW = MAX_ORDER + 6;

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic             bad;
    logic             pres;
  } tag_t;

  logic adv;
  logic [DIR_W-1:0] dcnt;
  logic h_bad;
  logic [FACE_W-1:0] h_face;
  logic [CW-1:0] h_x, h_y;

  logic a_v, b_v, c_v;
  tag_t a_tag, b_tag, c_tag;
  logic [FACE_W-1:0] a_face;
  logic [CW-1:0] a_x, a_y;

  logic [1:0] b_reg;
  logic signed [SW-1:0] b_nr, b_m, b_num, b_eqoff;

  logic [WIDE_W-1:0] c_before;
  logic signed [SW-1:0] c_jp;

  logic signed [SW-1:0] n_s, xa, ya, nm1;
  logic [3:0] slot;
  logic [FACE_W-1:0] fa;
  logic [2:0] sw;
  logic pres_a;

  logic signed [SW-1:0] jr, nr_b, m_b, num_b, jp;
  logic [1:0] reg_b;
  logic ks_b;
  logic [WIDE_W-1:0] n_w, npface, ncap, npix, prod, base_idx;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !empty && (dcnt == DIR_LAST);
  assign {h_bad, h_face, h_x, h_y} = head;

  always_comb begin
    n_s = SW'(1) << ord;
    nm1 = n_s - SW'(1);
    xa = $signed(SW'(h_x)) + SW'(STEP_X[dcnt]);
    ya = $signed(SW'(h_y)) + SW'(STEP_Y[dcnt]);
    slot = 4'd4;
    if (xa < 0) begin
      xa = xa + n_s;
      slot = slot - 4'd1;
    end else if (xa >= n_s) begin
      xa = xa - n_s;
      slot = slot + 4'd1;
    end
    if (ya < 0) begin
      ya = ya + n_s;
      slot = slot - 4'd3;
    end else if (ya >= n_s) begin
      ya = ya - n_s;
      slot = slot + 4'd3;
    end
    fa = ADJ_FACE[slot][h_face];
    sw = ADJ_SWAP[slot][h_face];
    pres_a = !h_bad && (fa != FACE_NONE);
    if (sw[0]) xa = nm1 - xa;
    if (sw[1]) ya = nm1 - ya;
    if (sw[2]) {xa, ya} = {ya, xa};
  end

  always_comb begin
    jr = ($signed(SW'(RING_ROW[a_face])) << ord) - $signed(SW'(a_x)) - $signed(SW'(a_y))
         - SW'(1);
    ks_b = 1'b0;
    if (jr < n_s) begin
      reg_b = REG_NORTH;
      nr_b = jr;
      m_b = jr - SW'(1);
    end else if (jr > n_s + (n_s <<< 1)) begin
      reg_b = REG_SOUTH;
      nr_b = (n_s <<< 2) - jr;
      m_b = nr_b + SW'(1);
    end else begin
      reg_b = REG_EQ;
      nr_b = n_s;
      m_b = n_s;
      ks_b = jr[0] ^ n_s[0];
    end
    num_b = $signed(SW'(RING_COL[a_face])) * nr_b + $signed(SW'(a_x)) - $signed(SW'(a_y))
            + SW'(1) + $signed(SW'(ks_b));
  end

  always_comb begin
    n_w = WIDE_W'(1) << ord;
    npface = WIDE_W'(1) << {ord, 1'b0};
    ncap = (npface << 1) - (n_w << 1);
    npix = (npface << 3) + (npface << 2);
    prod = WIDE_W'(b_nr) * WIDE_W'(b_m);
    jp = (b_num + $signed(SW'(b_num < 0))) >>> 1;
    if (jp > (n_s <<< 2)) jp = jp - (n_s <<< 2);
    else if (jp < 1) jp = jp + (n_s <<< 2);
    case (b_reg)
      REG_NORTH: base_idx = prod << 1;
      REG_SOUTH: base_idx = npix - (prod << 1);
      default: base_idx = ncap + (WIDE_W'(b_eqoff) << (5'(ord) + 5'd2));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (!empty) dcnt <= dcnt + 1'b1;
      a_v <= !empty;
      b_v <= a_v;
      c_v <= b_v;
      out_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag <= '{dir: dcnt, bad: h_bad, pres: pres_a};
      a_face <= pres_a ? fa : '0;
      a_x <= xa[CW-1:0];
      a_y <= ya[CW-1:0];
      b_tag <= a_tag;
      b_reg <= reg_b;
      b_nr <= nr_b;
      b_m <= m_b;
      b_num <= num_b;
      b_eqoff <= jr - n_s;
      c_tag <= b_tag;
      c_before <= base_idx;
      c_jp <= jp;
      direction <= c_tag.dir;
      neighbour_present <= c_tag.pres;
      index_out_of_range <= c_tag.bad;
      last_of_run <= c_tag.dir == DIR_LAST;
      neighbour_index <= c_tag.pres ? IDX_W'(c_before + WIDE_W'(c_jp) - 1) : '0;
    end
  end

endmodule

// File: rtl/core/sphere_pixel_ring_neighbours.sv
// The block takes one ring-ordered pixel index per transfer and returns its eight
// neighbours as eight result transfers, directions 0 to 7 in order, the eighth marked
// last. The decoder sends an index out of range straight to its output state, takes
// an equatorial pixel through its ring, phi, face and output states, and runs a
// four-step integer square root before these for a polar-cap pixel. The neighbour
// pipeline gives one result per cycle while it is fed and the output is not stalled.
// A four-entry queue separates the two, and grid_order must be written while idle.
module sphere_pixel_ring_neighbours #(
  parameter int MAX_ORDER = spr_pkg::MAX_ORDER_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [spr_pkg::ORD_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [spr_pkg::IDX_W-1:0] pixel_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [spr_pkg::DIR_W-1:0] direction,
  output logic [spr_pkg::IDX_W-1:0] neighbour_index,
  output logic                      neighbour_present,
  output logic                      index_out_of_range,
  output logic                      last_of_run
);
  import spr_pkg::*;

  localparam int CW = MAX_ORDER + 1;
  localparam int DW = 1 + FACE_W + 2 * CW;

  logic [ORD_W-1:0] grid_order;
  logic [ORD_W-1:0] ord;
  logic push, full, pop, empty;
  logic [DW-1:0] push_data, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_order <= '0;
    end else if (cfg_wr_en) begin
      grid_order <= cfg_wr_data;
    end
  end

  assign ord = (grid_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : grid_order;

  spr_front #(.MAX_ORDER(MAX_ORDER), .CW(CW), .DW(DW)) u_front (
    .clk(clk), .rst(rst), .ord(ord),
    .in_valid(in_valid), .in_ready(in_ready), .pixel_index(pixel_index),
    .push(push), .push_data(push_data), .full(full)
  );

  spr_fifo #(.DW(DW), .DEPTH(4)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .head(head), .empty(empty)
  );

  spr_back #(.MAX_ORDER(MAX_ORDER), .CW(CW), .DW(DW)) u_back (
    .clk(clk), .rst(rst), .ord(ord), .head(head), .empty(empty), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .direction(direction),
    .neighbour_index(neighbour_index), .neighbour_present(neighbour_present),
    .index_out_of_range(index_out_of_range), .last_of_run(last_of_run)
  );

endmodule

// File: rtl/core/spr_checker.sv
// Port-level checker for the sphere pixel neighbour block, bound to its top level.
// Depends on assert_macros.svh and spr_pkg.
`include "assert_macros.svh"

module spr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [spr_pkg::DIR_W-1:0] direction,
  input logic [spr_pkg::IDX_W-1:0] neighbour_index,
  input logic                      neighbour_present,
  input logic                      index_out_of_range,
  input logic                      last_of_run
);
  import spr_pkg::*;

  `SPR_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SPR_ASSERT_IMP(a_last_dir, clk, rst, out_valid, last_of_run == (direction == DIR_LAST), "last flag does not match direction")
  `SPR_ASSERT_IMP(a_absent_zero, clk, rst, out_valid && !neighbour_present, neighbour_index == '0, "absent neighbour has nonzero index")
  `SPR_ASSERT_IMP(a_bad_absent, clk, rst, out_valid && index_out_of_range, !neighbour_present, "neighbour present for bad index")
  `SPR_ASSERT_NXT(a_dir_step, clk, rst, out_valid && out_ready && !last_of_run, !out_valid || direction == DIR_W'($past(direction) + 3'd1), "direction out of sequence")

endmodule

bind sphere_pixel_ring_neighbours spr_checker u_spr_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .direction(direction), .neighbour_index(neighbour_index),
  .neighbour_present(neighbour_present), .index_out_of_range(index_out_of_range),
  .last_of_run(last_of_run)
);
